/* rtl/core/mcuf_pkg.sv */
// ----------------------------------------------------------------------------
// MC limited upwind flux divergence: shared definitions
// Widths, register indexes, payload types, controller states and the command
// and status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package mcuf_pkg;

  localparam int ValueW   = 32;
  localparam int CfgW     = 32;
  localparam int CfgIdxW  = 8;
  localparam int FracW    = 24;
  localparam int InvFracW = 16;
  localparam int FillW    = 3;
  localparam int MulW     = ValueW + CfgW;

  localparam logic [CfgIdxW-1:0] CfgAdvSpeed      = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgInvCellWidth  = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgSlopeThresh   = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgReconMode     = CfgIdxW'(3);

  localparam logic [CfgW-1:0] AdvSpeedReset     = CfgW'(16777216);
  localparam logic [CfgW-1:0] InvCellWidthReset = CfgW'(13107200);
  localparam logic [CfgW-1:0] SlopeThreshReset  = CfgW'(256);

  localparam logic [FillW-1:0] FillFull = FillW'(4);

  typedef struct packed {
    logic signed [ValueW-1:0] cell_value;
    logic                     restart;
  } mcuf_in_t;

  typedef struct packed {
    logic signed [ValueW-1:0] rate;
    logic                     saturated;
  } mcuf_out_t;

  typedef enum logic [1:0] {
    MulSlope,
    MulFlux,
    MulRate
  } mcuf_mul_sel_e;

  typedef enum logic [3:0] {
    StIdle,
    StDiff,
    StSlopeMul,
    StSlope,
    StFace,
    StFluxOp,
    StFluxMul,
    StFlux,
    StFluxSign,
    StRateOp,
    StRateMul,
    StRate,
    StEmit,
    StCommit
  } mcuf_state_e;

  typedef struct packed {
    logic          load;
    logic          diff;
    logic          mul;
    mcuf_mul_sel_e mul_sel;
    logic          slope;
    logic          face;
    logic          flux_op;
    logic          flux;
    logic          flux_sign;
    logic          rate_op;
    logic          rate;
    logic          emit;
    logic          commit;
  } mcuf_cmd_t;

  typedef struct packed {
    logic fill_ge2;
    logic fill_ge3;
    logic fill_ge4;
    logic out_free;
  } mcuf_stat_t;

endpackage

/* rtl/core/mcuf_ctrl.sv */
// ----------------------------------------------------------------------------
// MC limited upwind flux divergence: controller
// Steps one cell through difference, slope, face, flux and rate phases and
// issues the datapath commands for each phase.
// ----------------------------------------------------------------------------
module mcuf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mcuf_pkg::mcuf_stat_t stat_i,
  output mcuf_pkg::mcuf_cmd_t  cmd_o
);
  import mcuf_pkg::*;

  mcuf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDiff;
        end
      end
      StDiff: begin
        cmd_o.diff = 1'b1;
        state_d    = stat_i.fill_ge2 ? StSlopeMul : StCommit;
      end
      StSlopeMul: begin
        cmd_o.mul     = 1'b1;
        cmd_o.mul_sel = MulSlope;
        state_d       = StSlope;
      end
      StSlope: begin
        cmd_o.slope = 1'b1;
        state_d     = StFace;
      end
      StFace: begin
        cmd_o.face = 1'b1;
        state_d    = stat_i.fill_ge3 ? StFluxOp : StCommit;
      end
      StFluxOp: begin
        cmd_o.flux_op = 1'b1;
        state_d       = StFluxMul;
      end
      StFluxMul: begin
        cmd_o.mul     = 1'b1;
        cmd_o.mul_sel = MulFlux;
        state_d       = StFlux;
      end
      StFlux: begin
        cmd_o.flux = 1'b1;
        state_d    = StFluxSign;
      end
      StFluxSign: begin
        cmd_o.flux_sign = 1'b1;
        state_d         = stat_i.fill_ge4 ? StRateOp : StCommit;
      end
      StRateOp: begin
        cmd_o.rate_op = 1'b1;
        state_d       = StRateMul;
      end
      StRateMul: begin
        cmd_o.mul     = 1'b1;
        cmd_o.mul_sel = MulRate;
        state_d       = StRate;
      end
      StRate: begin
        cmd_o.rate = 1'b1;
        state_d    = StEmit;
      end
      StEmit: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = StCommit;
        end
      end
      StCommit: begin
        cmd_o.commit = 1'b1;
        state_d      = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

/* rtl/core/mcuf_dpath.sv */
// ----------------------------------------------------------------------------
// MC limited upwind flux divergence: datapath
// Configuration registers, the cell window, one shared multiplier and the
// rounding, limiting and saturation logic, with the result register.
// ----------------------------------------------------------------------------
module mcuf_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mcuf_pkg::mcuf_cmd_t                 cmd_i,
  output mcuf_pkg::mcuf_stat_t                stat_o,
  input  mcuf_pkg::mcuf_in_t                  in_data_i,
  input  logic                                cfg_we_i,
  input  logic [mcuf_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [mcuf_pkg::CfgW-1:0]           cfg_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output mcuf_pkg::mcuf_out_t                 res_data_o
);
  import mcuf_pkg::*;

  localparam int FluxTW = MulW - FracW;
  localparam int RateTW = MulW - InvFracW;
  localparam logic [MulW-1:0] FluxHalf = MulW'(1) << (FracW - 1);
  localparam logic [MulW-1:0] RateHalf = MulW'(1) << (InvFracW - 1);

  function automatic logic [ValueW-1:0] clip_face(input logic [ValueW+1:0] v);
    logic [2:0] top;
    top = v[ValueW+1:ValueW-1];
    if (top == 3'b000 || top == 3'b111) begin
      return v[ValueW-1:0];
    end
    return v[ValueW+1] ? {1'b1, {(ValueW-1){1'b0}}} : {1'b0, {(ValueW-1){1'b1}}};
  endfunction

  // Configuration.
  logic [CfgW-1:0] adv_mag_q, inv_q, thr_q;
  logic            adv_neg_q, mode_q;

  // Window state.
  logic [ValueW-1:0] prev_q, pprev_q, prf_q, pflux_q;
  logic [FillW-1:0]  fill_q;

  // Working registers.
  logic [ValueW-1:0] cur_q;
  logic [ValueW-1:0] ma_q, mb_q, md_q;
  logic              a_neg_q, b_neg_q, d_neg_q;
  logic [MulW-1:0]   mul_q;
  logic [ValueW-1:0] hmag_q;
  logic              hneg_q;
  logic [ValueW-1:0] left_q, right_q;
  logic [ValueW-1:0] opa_q;
  logic              pneg_q;
  logic [ValueW-1:0] fmag_q, f_q;
  logic              fneg_q;
  logic [ValueW-1:0] rmag_q;
  logic              rneg_q, rsat_q;
  mcuf_out_t         out_q;
  logic              out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adv_mag_q <= AdvSpeedReset;
      adv_neg_q <= 1'b0;
      inv_q     <= InvCellWidthReset;
      thr_q     <= SlopeThreshReset;
      mode_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgAdvSpeed: begin
          adv_neg_q <= cfg_data_i[CfgW-1];
          adv_mag_q <= cfg_data_i[CfgW-1] ? (CfgW'(0) - cfg_data_i) : cfg_data_i;
        end
        CfgInvCellWidth: inv_q  <= cfg_data_i;
        CfgSlopeThresh:  thr_q  <= cfg_data_i;
        CfgReconMode:    mode_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      pprev_q <= '0;
      prf_q   <= '0;
      pflux_q <= '0;
      fill_q  <= '0;
    end else if (cmd_i.load && in_data_i.restart) begin
      prev_q  <= '0;
      pprev_q <= '0;
      prf_q   <= '0;
      pflux_q <= '0;
      fill_q  <= '0;
    end else if (cmd_i.commit) begin
      pprev_q <= prev_q;
      prev_q  <= cur_q;
      if (stat_o.fill_ge2) begin
        prf_q <= right_q;
      end
      if (stat_o.fill_ge3) begin
        pflux_q <= f_q;
      end
      if (!stat_o.fill_ge4) begin
        fill_q <= fill_q + FillW'(1);
      end
    end
  end

  assign stat_o.fill_ge2 = (fill_q >= FillW'(2));
  assign stat_o.fill_ge3 = (fill_q >= FillW'(3));
  assign stat_o.fill_ge4 = (fill_q >= FillFull);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  // Differences, taken both ways so that the magnitude is a plain selection.
  logic [ValueW:0] a_fw, a_bw, b_fw, b_bw, d_fw, d_bw;
  assign a_fw = {prev_q[ValueW-1], prev_q} - {pprev_q[ValueW-1], pprev_q};
  assign a_bw = {pprev_q[ValueW-1], pprev_q} - {prev_q[ValueW-1], prev_q};
  assign b_fw = {cur_q[ValueW-1], cur_q} - {prev_q[ValueW-1], prev_q};
  assign b_bw = {prev_q[ValueW-1], prev_q} - {cur_q[ValueW-1], cur_q};
  assign d_fw = {cur_q[ValueW-1], cur_q} - {pprev_q[ValueW-1], pprev_q};
  assign d_bw = {pprev_q[ValueW-1], pprev_q} - {cur_q[ValueW-1], cur_q};

  // Shared multiplier operands.
  logic [ValueW-1:0] mul_a;
  logic [CfgW-1:0]   mul_b;
  always_comb begin
    unique case (cmd_i.mul_sel)
      MulSlope: begin
        mul_a = ma_q;
        mul_b = CfgW'(mb_q);
      end
      MulFlux: begin
        mul_a = opa_q;
        mul_b = adv_mag_q;
      end
      MulRate: begin
        mul_a = opa_q;
        mul_b = inv_q;
      end
      default: begin
        mul_a = opa_q;
        mul_b = inv_q;
      end
    endcase
  end

  // Limited slope.
  logic              below;
  logic [ValueW+1:0] s4a, s4b, sd, smin, ssel;
  logic [ValueW+2:0] sround;
  always_comb begin
    below = ((ma_q != '0) && (mb_q != '0) && (a_neg_q != b_neg_q))
         || ((mul_q[MulW-1:CfgW] == '0) && (mul_q[CfgW-1:0] < thr_q));
    s4a  = {ma_q, 2'b00};
    s4b  = {mb_q, 2'b00};
    sd   = {2'b00, md_q};
    smin = sd;
    if (s4a < smin) begin
      smin = s4a;
    end
    if (s4b < smin) begin
      smin = s4b;
    end
    ssel   = mode_q ? sd : smin;
    sround = {1'b0, ssel} + (ValueW+3)'(2);
  end

  // Face values.
  logic [ValueW+1:0] q_ext, h_ext, face_plus, face_minus;
  assign q_ext      = {{2{prev_q[ValueW-1]}}, prev_q};
  assign h_ext      = {2'b00, hmag_q};
  assign face_plus  = q_ext + h_ext;
  assign face_minus = q_ext - h_ext;

  // Flux operand.
  logic [ValueW-1:0] u_sel;
  assign u_sel = adv_neg_q ? left_q : prf_q;

  // Flux rounding and limiting.
  logic [MulW-1:0]   flux_rnd;
  logic [FluxTW-1:0] flux_t;
  logic [ValueW-1:0] flux_lim;
  assign flux_rnd = mul_q + FluxHalf;
  assign flux_t   = flux_rnd[MulW-1:FracW];
  assign flux_lim = {pneg_q, {(ValueW-1){~pneg_q}}};

  // Rate operand.
  logic [ValueW:0] r_fw, r_bw;
  assign r_fw = {pflux_q[ValueW-1], pflux_q} - {f_q[ValueW-1], f_q};
  assign r_bw = {f_q[ValueW-1], f_q} - {pflux_q[ValueW-1], pflux_q};

  // Rate rounding and saturation.
  logic [MulW-1:0]   rate_rnd;
  logic [RateTW-1:0] rate_t;
  logic              rate_clip;
  assign rate_rnd  = mul_q + RateHalf;
  assign rate_t    = rate_rnd[MulW-1:InvFracW];
  assign rate_clip = rate_t > RateTW'(flux_lim);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_q <= in_data_i.cell_value;
    end
    if (cmd_i.diff) begin
      a_neg_q <= a_fw[ValueW];
      ma_q    <= a_fw[ValueW] ? a_bw[ValueW-1:0] : a_fw[ValueW-1:0];
      b_neg_q <= b_fw[ValueW];
      mb_q    <= b_fw[ValueW] ? b_bw[ValueW-1:0] : b_fw[ValueW-1:0];
      d_neg_q <= d_fw[ValueW];
      md_q    <= d_fw[ValueW] ? d_bw[ValueW-1:0] : d_fw[ValueW-1:0];
    end
    if (cmd_i.mul) begin
      mul_q <= MulW'(mul_a) * MulW'(mul_b);
    end
    if (cmd_i.slope) begin
      hneg_q <= mode_q ? d_neg_q : a_neg_q;
      hmag_q <= (!mode_q && below) ? '0 : sround[ValueW+1:2];
    end
    if (cmd_i.face) begin
      right_q <= clip_face(hneg_q ? face_minus : face_plus);
      left_q  <= clip_face(hneg_q ? face_plus : face_minus);
    end
    if (cmd_i.flux_op) begin
      opa_q  <= u_sel[ValueW-1] ? (ValueW'(0) - u_sel) : u_sel;
      pneg_q <= u_sel[ValueW-1] ^ adv_neg_q;
    end
    if (cmd_i.flux) begin
      fneg_q <= pneg_q;
      fmag_q <= (flux_t > FluxTW'(flux_lim)) ? flux_lim : flux_t[ValueW-1:0];
    end
    if (cmd_i.flux_sign) begin
      f_q <= fneg_q ? (ValueW'(0) - fmag_q) : fmag_q;
    end
    if (cmd_i.rate_op) begin
      pneg_q <= r_fw[ValueW];
      opa_q  <= r_fw[ValueW] ? r_bw[ValueW-1:0] : r_fw[ValueW-1:0];
    end
    if (cmd_i.rate) begin
      rneg_q <= pneg_q;
      rsat_q <= rate_clip;
      rmag_q <= rate_clip ? flux_lim : rate_t[ValueW-1:0];
    end
    if (cmd_i.emit) begin
      out_q.rate      <= $signed(rneg_q ? (ValueW'(0) - rmag_q) : rmag_q);
      out_q.saturated <= rsat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_data_o  = out_q;

endmodule

/* rtl/core/mc_limited_upwind_flux_divergence_core.sv */
// ----------------------------------------------------------------------------
// MC limited upwind flux divergence core
// Cell averages (signed Q8.24) stream in grid order, one beat per cell; a set
// restart bit clears the window first. Each cell reconstructs the face values
// of the previous cell with a monotonized-central limited slope (or the
// central slope in recon_mode 1), forms the upwind flux and returns the
// saturated flux divergence of the cell two back; the first four cells of a
// sweep give no result. A cell passes through more states once the window is
// full than while it fills, and waits with its result until the previous one
// is taken. The slope product, the flux and the rate go one after another
// through a single shared 32 by 32 bit multiplier, and a new cell is taken
// only when the last is done. A finished result sits in an output register,
// so the next cell is taken in while it waits. Configuration writes are
// always ready and must only be made while the core is idle.
// ----------------------------------------------------------------------------
module mc_limited_upwind_flux_divergence_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  mcuf_pkg::mcuf_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mcuf_pkg::mcuf_out_t           res_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mcuf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mcuf_pkg::CfgW-1:0]     cfg_data_i
);
  import mcuf_pkg::*;

  mcuf_cmd_t  cmd;
  mcuf_stat_t stat;

  assign cfg_ready_o = 1'b1;

  mcuf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mcuf_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_data_o  (res_data_o)
  );

endmodule
